// ===== rtl/ssd_pkg.sv =====
// Shared types and constants for the SPI stepper-driver register model.
// Used by ssd_mem, ssd_core and the top level; depends on nothing else.
package ssd_pkg;

  localparam int unsigned REG_COUNT = 128;
  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAME_LEN = 5;

  localparam logic [1:0] REQ_SELECT = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_SUPPLY = 2'd2;
  localparam logic [1:0] REQ_ERROR  = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_STATUS  = 7'h01;
  localparam logic [ADDR_W-1:0] ADDR_VERSION = 7'h04;
  localparam logic [ADDR_W-1:0] ADDR_FIXED   = 7'h6F;

  localparam logic [DATA_W-1:0] VERSION_VALUE = 32'h1100_0000 | 32'h0000_0040;
  localparam logic [DATA_W-1:0] FIXED_VALUE   = 32'h8000_0000;

  localparam logic [3:0] POS_LIMIT = 4'd8;

  typedef struct packed {
    logic              we;
    logic              clear;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [7:0]        miso_byte;
    logic              frame_done;
    logic              frame_write;
    logic [ADDR_W-1:0] frame_address;
    logic [DATA_W-1:0] frame_value;
  } result_t;

endpackage

// ===== rtl/ssd_mem.sv =====
// Register file storage: a single-port-write, registered-read memory.
// Per-entry valid flops make unwritten or cleared entries read as zero; uses ssd_pkg.
module ssd_mem #(
  parameter int unsigned RegCount = ssd_pkg::REG_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ssd_pkg::mem_cmd_t          cmd,
  output logic [ssd_pkg::DATA_W-1:0] rdata
);

  localparam int unsigned IdxW = $clog2(RegCount);

  logic [ssd_pkg::DATA_W-1:0] ram_r [RegCount];
  logic [ssd_pkg::DATA_W-1:0] ram_q_r;
  logic [IdxW-1:0]            raddr_q_r;
  logic [RegCount-1:0]        valid_r;
  logic [IdxW-1:0]            widx;
  logic [IdxW-1:0]            ridx;

  assign widx = cmd.waddr[IdxW-1:0];
  assign ridx = cmd.raddr[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      ram_r[widx] <= cmd.wdata;
    end
    ram_q_r   <= ram_r[ridx];
    raddr_q_r <= ridx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.we) begin
      valid_r[widx] <= 1'b1;
    end
  end

  assign rdata = valid_r[raddr_q_r] ? ram_q_r : '0;

endmodule

// ===== rtl/ssd_core.sv =====
// Slave state and the single-pass request logic: select edges, byte shifting,
// supply changes and frame completion. Uses ssd_pkg; drives ssd_mem.
module ssd_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [1:0]                 req_type,
  input  logic                       level,
  input  logic [7:0]                 mosi_byte,
  input  logic [ssd_pkg::DATA_W-1:0] rf_rdata,
  output ssd_pkg::mem_cmd_t          mem_cmd,
  output ssd_pkg::result_t           result
);

  logic                       select_high_r, select_high_nxt;
  logic                       supply_on_r, supply_on_nxt;
  logic [1:0]                 fault_r, fault_nxt;
  logic [3:0]                 pos_r, pos_nxt;
  logic [7:0]                 recv_r  [ssd_pkg::FRAME_LEN];
  logic [7:0]                 reply_r [ssd_pkg::FRAME_LEN];
  logic [7:0]                 reply_nxt [ssd_pkg::FRAME_LEN];
  logic [ssd_pkg::DATA_W-1:0] pending_r, pending_nxt;
  logic                       recv_we;
  logic [2:0]                 pidx;
  logic [ssd_pkg::ADDR_W-1:0] addr;
  logic [ssd_pkg::DATA_W-1:0] wdata;
  logic                       in_frame;

  assign pidx     = pos_r[2:0];
  assign in_frame = (pos_r < 4'(ssd_pkg::FRAME_LEN));
  assign addr     = recv_r[0][ssd_pkg::ADDR_W-1:0];
  assign wdata    = {recv_r[1], recv_r[2], recv_r[3], recv_r[4]};

  always_comb begin
    select_high_nxt = select_high_r;
    supply_on_nxt   = supply_on_r;
    fault_nxt       = fault_r;
    pos_nxt         = pos_r;
    pending_nxt     = pending_r;
    for (int i = 0; i < ssd_pkg::FRAME_LEN; i++) begin
      reply_nxt[i] = reply_r[i];
    end
    recv_we       = 1'b0;
    mem_cmd       = '0;
    mem_cmd.raddr = addr;
    mem_cmd.waddr = addr;
    mem_cmd.wdata = wdata;
    result        = '0;

    case (req_type)
      ssd_pkg::REQ_SELECT: begin
        if (select_high_r && !level) begin
          pos_nxt      = '0;
          reply_nxt[0] = supply_on_r ? {7'b0, fault_r[0]} : 8'h00;
          reply_nxt[1] = pending_r[31:24];
          reply_nxt[2] = pending_r[23:16];
          reply_nxt[3] = pending_r[15:8];
          reply_nxt[4] = pending_r[7:0];
        end else if (!select_high_r && level && !in_frame) begin
          result.frame_done    = 1'b1;
          result.frame_address = addr;
          if (recv_r[0][7]) begin
            result.frame_write = 1'b1;
            result.frame_value = wdata;
            if (!supply_on_r) begin
              pending_nxt = '0;
            end else if (addr == ssd_pkg::ADDR_STATUS) begin
              fault_nxt   = fault_r & ~wdata[1:0];
              pending_nxt = rf_rdata;
            end else begin
              mem_cmd.we  = fire;
              pending_nxt = wdata;
            end
          end else begin
            if (!supply_on_r) begin
              pending_nxt = '0;
            end else if (addr == ssd_pkg::ADDR_STATUS) begin
              pending_nxt = {30'b0, fault_r};
              fault_nxt   = 2'b00;
            end else if (addr == ssd_pkg::ADDR_VERSION) begin
              pending_nxt = ssd_pkg::VERSION_VALUE;
            end else if (addr == ssd_pkg::ADDR_FIXED) begin
              pending_nxt = ssd_pkg::FIXED_VALUE;
            end else begin
              pending_nxt = rf_rdata;
            end
            result.frame_value = pending_nxt;
          end
        end
        select_high_nxt = level;
      end
      ssd_pkg::REQ_BYTE: begin
        if (!select_high_r) begin
          if (in_frame) begin
            recv_we          = fire;
            result.miso_byte = reply_r[pidx];
          end
          if (pos_r < ssd_pkg::POS_LIMIT) begin
            pos_nxt = pos_r + 4'd1;
          end
        end
      end
      ssd_pkg::REQ_SUPPLY: begin
        if (level && !supply_on_r) begin
          mem_cmd.clear = fire;
          fault_nxt     = 2'b01;
          pending_nxt   = '0;
          supply_on_nxt = 1'b1;
        end else if (!level) begin
          supply_on_nxt = 1'b0;
        end
      end
      ssd_pkg::REQ_ERROR: begin
        if (supply_on_r) begin
          fault_nxt = fault_r | 2'b10;
        end
      end
      default: begin
        select_high_nxt = select_high_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_high_r <= 1'b1;
      supply_on_r   <= 1'b0;
      fault_r       <= 2'b00;
      pos_r         <= '0;
      pending_r     <= '0;
      for (int i = 0; i < ssd_pkg::FRAME_LEN; i++) begin
        reply_r[i] <= '0;
      end
    end else if (fire) begin
      select_high_r <= select_high_nxt;
      supply_on_r   <= supply_on_nxt;
      fault_r       <= fault_nxt;
      pos_r         <= pos_nxt;
      pending_r     <= pending_nxt;
      for (int i = 0; i < ssd_pkg::FRAME_LEN; i++) begin
        reply_r[i] <= reply_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (recv_we) begin
      recv_r[pidx] <= mosi_byte;
    end
  end

endmodule

// ===== rtl/spi_stepper_driver_register_model_top.sv =====
// An accepted request moves from the input register to the result register when the output
// is free or drained. Throughput: one request per cycle, unless the output stalls.
// The register file read is prefetched from the stored address byte each cycle.
// Reset: select high, supply off, status and counters cleared, pending read zero;
// the register file's valid flops clear at once, so no clearing pass is needed.
// Top level: input and output registers around ssd_core and ssd_mem (ssd_pkg).
module spi_stepper_driver_register_model_top #(
  parameter int unsigned RegCount = ssd_pkg::REG_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // level [0], mosi_byte [8:1], zero fill [15:9]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // miso_byte [7:0], frame_address [14:8],
                                  // frame_value [46:15], zero fill [47]
  output logic [1:0]  out_tuser   // frame_done [0], frame_write [1]
);

  logic                       s1_valid_r;
  logic [1:0]                 s1_type_r;
  logic                       s1_level_r;
  logic [7:0]                 s1_mosi_r;
  logic                       move;
  logic                       out_valid_r;
  ssd_pkg::result_t           out_res_r;
  ssd_pkg::result_t           result;
  ssd_pkg::mem_cmd_t          mem_cmd;
  logic [ssd_pkg::DATA_W-1:0] rf_rdata;

  assign move      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_type_r  <= in_tuser;
      s1_level_r <= in_tdata[0];
      s1_mosi_r  <= in_tdata[8:1];
    end
    if (move) begin
      out_res_r <= result;
    end
  end

  ssd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (move),
    .req_type  (s1_type_r),
    .level     (s1_level_r),
    .mosi_byte (s1_mosi_r),
    .rf_rdata  (rf_rdata),
    .mem_cmd   (mem_cmd),
    .result    (result)
  );

  ssd_mem #(
    .RegCount (RegCount)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mem_cmd),
    .rdata (rf_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.frame_value, out_res_r.frame_address,
                       out_res_r.miso_byte};
  assign out_tuser  = {out_res_r.frame_write, out_res_r.frame_done};

  a_done_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7:0] == 8'h00)
    else $error("completed frame carries a reply byte");

  a_idle_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] == 1'b0 && out_tdata[47:8] == '0)
    else $error("frame fields set without a completed frame");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !move |=> s1_valid_r && $stable(s1_type_r) && $stable(s1_mosi_r))
    else $error("stalled request lost from the input register");

  a_mem_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.we && mem_cmd.clear))
    else $error("register file written and cleared together");

endmodule
